// ===== hdl/rsdt_pkg.sv =====
package rsdt_pkg;

  localparam int CAPACITY_DEF       = 64;
  localparam int IDENTITY_BYTES_DEF = 6;
  localparam int LABEL_BYTES_DEF    = 32;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_ORDER   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic RADIO_WIFI = 1'b0;

  localparam logic [1:0] KIND_AP  = 2'd0;
  localparam logic [1:0] KIND_STA = 2'd1;
  localparam logic [1:0] KIND_BLE = 2'd2;

  typedef struct packed {
    logic        radio;
    logic [1:0]  kind;
    logic [47:0] time_us;
    logic [47:0] identity;
    logic [5:0]  identity_length;
    logic [7:0]  label_length;
    logic signed [7:0] rssi_dbm;
    logic [23:0] frequency_khz;
    logic [7:0]  channel;
    logic [31:0] facts_word;
  } sighting_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] sighting_count;
    logic        take_label;
    logic [6:0]  entries_used;
    logic        catalog_complete;
    logic [31:0] invalid_total;
    logic [31:0] out_of_order_total;
    logic [31:0] dropped_total;
  } result_t;

  // key part of an entry, scanned on every lookup
  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] identity;
  } key_t;

  // body of an entry, read once on a hit
  typedef struct packed {
    logic [47:0] last_seen;
    logic [31:0] count;
    logic signed [7:0] strongest_rssi;
    logic [7:0]  label_length;
  } body_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== hdl/radio_sighting_dedup_table.sv =====
// Channel | Dir | Handshake          | Beat
// in      | in  | in_valid/in_ready  | rsdt_pkg::sighting_t
// out     | out | out_valid/out_ready| rsdt_pkg::result_t
//
// One item at a time. An invalid sighting is rejected in the scan state and goes
// straight to the output state. A valid one scans the key memory one entry a cycle:
// a miss is appended (or dropped when the table is full) as the scan ends; a hit goes
// on to read and write back the entry (states S_READ, S_UPD) before its result. The
// key memory has a single read port; the block returns to idle after each result
// beat. Reset is synchronous; no memory clearing is needed since only filled entries
// are read. in_ready drops while an item is in work or its result waits on out_ready.
module radio_sighting_dedup_table #(
  parameter int CAPACITY       = rsdt_pkg::CAPACITY_DEF,
  parameter int IDENTITY_BYTES = rsdt_pkg::IDENTITY_BYTES_DEF,
  parameter int LABEL_BYTES    = rsdt_pkg::LABEL_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsdt_pkg::sighting_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rsdt_pkg::result_t   out_data
);
  import rsdt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state;
  sighting_t     item;
  logic [CW-1:0] used;
  logic          complete;
  logic [31:0]   inv_cnt, ooo_cnt, drop_cnt;
  logic [CW-1:0] scan_idx;   // address issued this cycle
  logic          cmp_vld;    // key read data valid
  logic [AW-1:0] cmp_idx;
  logic [AW-1:0] hit_idx;
  result_t       res;

  key_t  key_mem  [CAPACITY];
  body_t body_mem [CAPACITY];
  key_t  key_rd;
  body_t body_rd;

  logic          key_we, body_we;
  logic [AW-1:0] wr_idx;
  key_t          key_wd;
  body_t         body_wd;
  logic [AW-1:0] body_ra;

  // side fields that are never read back
  logic [47:0] first_seen_mem [CAPACITY];
  logic [7:0]  latest_rssi_mem [CAPACITY];
  logic [23:0] freq_mem [CAPACITY];
  logic [7:0]  chan_mem [CAPACITY];
  logic [31:0] facts_mem [CAPACITY];
  logic        side_we, strong_we;

  logic valid_in;
  assign valid_in = ((item.radio == RADIO_WIFI) ?
                     (item.kind == KIND_AP || item.kind == KIND_STA) :
                     (item.kind == KIND_BLE)) &&
                    (item.time_us != 48'd0) &&
                    (item.identity_length == 6'(IDENTITY_BYTES)) &&
                    ({1'b0, item.label_length} <= 9'(LABEL_BYTES));

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // key and body memory reads and writes; the key memory is read one entry a cycle during the scan
  always_ff @(posedge clk) begin
    key_rd  <= key_mem[scan_idx[AW-1:0]];
    body_rd <= body_mem[body_ra];
    if (key_we) key_mem[wr_idx] <= key_wd;
    if (body_we) body_mem[wr_idx] <= body_wd;
    if (side_we) begin
      latest_rssi_mem[wr_idx] <= item.rssi_dbm;
    end
    if (key_we) first_seen_mem[wr_idx] <= item.time_us;
    if (strong_we) begin
      freq_mem[wr_idx]  <= item.frequency_khz;
      chan_mem[wr_idx]  <= item.channel;
      facts_mem[wr_idx] <= item.facts_word;
    end
  end

  assign body_ra = hit_idx;

  // update decision from the body read
  logic        later, stronger, take;
  logic [31:0] cnt_new;
  assign later    = item.time_us >= body_rd.last_seen;
  assign stronger = item.rssi_dbm > body_rd.strongest_rssi;
  assign take     = (item.label_length != 8'd0) &&
                    (stronger || body_rd.label_length == 8'd0);
  assign cnt_new  = sat_inc(body_rd.count);

  logic hit_now;
  assign hit_now = cmp_vld && key_rd.kind == item.kind && key_rd.identity == item.identity;

  always_comb begin
    key_we    = 1'b0;
    body_we   = 1'b0;
    side_we   = 1'b0;
    strong_we = 1'b0;
    wr_idx    = hit_idx;
    key_wd    = '{kind: item.kind, identity: item.identity};
    body_wd   = '{last_seen: item.time_us, count: cnt_new, strongest_rssi:
                  (stronger ? item.rssi_dbm : body_rd.strongest_rssi),
                  label_length: (take ? item.label_length : body_rd.label_length)};
    if (state == S_SCAN && valid_in && !hit_now && scan_idx == used && !cmp_vld &&
        used < CW'(CAPACITY)) begin
      // miss: append
      wr_idx    = used[AW-1:0];
      key_we    = 1'b1;
      body_we   = 1'b1;
      side_we   = 1'b1;
      strong_we = 1'b1;
      body_wd   = '{last_seen: item.time_us, count: 32'd1, strongest_rssi: item.rssi_dbm,
                    label_length: item.label_length};
    end else if (state == S_UPD && later) begin
      body_we   = 1'b1;
      side_we   = 1'b1;
      strong_we = stronger;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      complete <= 1'b1;
      inv_cnt  <= '0;
      ooo_cnt  <= '0;
      drop_cnt <= '0;
      cmp_vld  <= 1'b0;
      scan_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item     <= in_data;
            scan_idx <= '0;
            cmp_vld  <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!valid_in) begin
            inv_cnt  <= sat_inc(inv_cnt);
            complete <= 1'b0;
            res      <= '{status: ST_INVALID, default: '0};
            state    <= S_OUT;
          end else if (hit_now) begin
            hit_idx <= cmp_idx;
            cmp_vld <= 1'b0;
            state   <= S_READ;
          end else if (scan_idx == used) begin
            // last compare done (or table empty) and no hit
            if (!cmp_vld) begin
              if (used < CW'(CAPACITY)) begin
                res  <= '{status: ST_ADDED, entry_index: 6'(used),
                          sighting_count: 32'd1,
                          take_label: (item.label_length != 8'd0), default: '0};
                used <= used + CW'(1);
              end else begin
                res      <= '{status: ST_FULL, default: '0};
                drop_cnt <= sat_inc(drop_cnt);
                complete <= 1'b0;
              end
              state <= S_OUT;
            end
            cmp_vld <= 1'b0;
          end else begin
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx[AW-1:0];
            scan_idx <= scan_idx + CW'(1);
          end
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          if (later) begin
            res <= '{status: ST_UPDATED, entry_index: 6'(hit_idx),
                     sighting_count: cnt_new, take_label: take, default: '0};
          end else begin
            res      <= '{status: ST_ORDER, default: '0};
            ooo_cnt  <= sat_inc(ooo_cnt);
            complete <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // fold in the running totals at the output
  always_comb begin
    out_data                    = res;
    out_data.entries_used       = 7'(used);
    out_data.catalog_complete   = complete;
    out_data.invalid_total      = inv_cnt;
    out_data.out_of_order_total = ooo_cnt;
    out_data.dropped_total      = drop_cnt;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import rsdt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = CAPACITY_DEF;
  localparam int N_RANDOM = 1950;
  localparam longint CYCLE_LIMIT = 1500000;

  // Expected-result tracker: holds its own copy of the table and counters.
  class dedup_scoreboard;
    logic [1:0]  tbl_kind [CAP];
    logic [47:0] tbl_id [CAP];
    logic [47:0] tbl_last [CAP];
    logic [31:0] tbl_count [CAP];
    logic signed [7:0] tbl_strong [CAP];
    logic [7:0]  tbl_label [CAP];
    int unsigned used;
    logic        complete;
    logic [31:0] n_invalid, n_order, n_dropped;
    result_t     pending[$];
    int          errors;

    function new();
      used = 0;
      complete = 1'b1;
      n_invalid = '0;
      n_order = '0;
      n_dropped = '0;
      errors = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Predict the result of one accepted sighting beat.
    function void note_sighting(sighting_t s);
      result_t r;
      int hit;
      logic ok;
      logic take;
      r = '0;
      ok = (s.radio == RADIO_WIFI) ? (s.kind == KIND_AP || s.kind == KIND_STA)
                                   : (s.kind == KIND_BLE);
      if (!ok || s.time_us == 0 || s.identity_length != IDENTITY_BYTES_DEF ||
          s.label_length > LABEL_BYTES_DEF) begin
        n_invalid = bump(n_invalid);
        complete = 1'b0;
        r.status = ST_INVALID;
      end else begin
        hit = -1;
        for (int i = 0; i < used; i++) begin
          if (hit < 0 && tbl_kind[i] == s.kind && tbl_id[i] == s.identity) hit = i;
        end
        if (hit >= 0) begin
          if (s.time_us < tbl_last[hit]) begin
            n_order = bump(n_order);
            complete = 1'b0;
            r.status = ST_ORDER;
          end else begin
            tbl_last[hit] = s.time_us;
            tbl_count[hit] = bump(tbl_count[hit]);
            if (s.rssi_dbm > tbl_strong[hit]) begin
              tbl_strong[hit] = s.rssi_dbm;
              take = s.label_length != 0;
            end else begin
              take = tbl_label[hit] == 0 && s.label_length != 0;
            end
            if (take) tbl_label[hit] = s.label_length;
            r.status = ST_UPDATED;
            r.entry_index = hit[5:0];
            r.sighting_count = tbl_count[hit];
            r.take_label = take;
          end
        end else if (used >= CAP) begin
          n_dropped = bump(n_dropped);
          complete = 1'b0;
          r.status = ST_FULL;
        end else begin
          tbl_kind[used] = s.kind;
          tbl_id[used] = s.identity;
          tbl_last[used] = s.time_us;
          tbl_count[used] = 32'd1;
          tbl_strong[used] = s.rssi_dbm;
          tbl_label[used] = s.label_length;
          r.status = ST_ADDED;
          r.entry_index = used[5:0];
          r.sighting_count = 32'd1;
          r.take_label = s.label_length != 0;
          used++;
        end
      end
      r.entries_used = used[6:0];
      r.catalog_complete = complete;
      r.invalid_total = n_invalid;
      r.out_of_order_total = n_order;
      r.dropped_total = n_dropped;
      pending.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(result_t a);
      result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending: %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.entry_index !== e.entry_index) begin
        $error("entry_index exp %0d got %0d", e.entry_index, a.entry_index); errors++;
      end
      if (a.sighting_count !== e.sighting_count) begin
        $error("sighting_count exp %0d got %0d", e.sighting_count, a.sighting_count);
        errors++;
      end
      if (a.take_label !== e.take_label) begin
        $error("take_label exp %0d got %0d", e.take_label, a.take_label); errors++;
      end
      if (a.entries_used !== e.entries_used) begin
        $error("entries_used exp %0d got %0d", e.entries_used, a.entries_used); errors++;
      end
      if (a.catalog_complete !== e.catalog_complete) begin
        $error("catalog_complete exp %0d got %0d", e.catalog_complete,
               a.catalog_complete);
        errors++;
      end
      if (a.invalid_total !== e.invalid_total) begin
        $error("invalid_total exp %0d got %0d", e.invalid_total, a.invalid_total);
        errors++;
      end
      if (a.out_of_order_total !== e.out_of_order_total) begin
        $error("out_of_order_total exp %0d got %0d", e.out_of_order_total,
               a.out_of_order_total);
        errors++;
      end
      if (a.dropped_total !== e.dropped_total) begin
        $error("dropped_total exp %0d got %0d", e.dropped_total, a.dropped_total);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sighting_t in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  result_t   out_data;

  dedup_scoreboard sb = new();
  longint    cycles = 0;

  // Pool of identities so that repeats hit the table.
  logic [47:0] id_pool [16];
  logic [47:0] clock_us = 48'd1000;

  radio_sighting_dedup_table i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) sb.note_sighting(in_data);
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver stall pattern: phases of always-ready and of random stalls.
  initial begin
    int phase;
    phase = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      phase = (phase + 1) % 600;
      if (phase < 150) out_ready <= 1'b1;
      else if (phase < 400) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 4) == 0);
    end
  end

  // Present one sighting beat and hold it until accepted; valid stays up for the
  // next beat unless the caller lowers it.
  task automatic send_sighting(sighting_t s);
    in_data <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic sighting_t good_sighting(logic [1:0] k, logic [47:0] id,
                                              logic [47:0] t);
    sighting_t s;
    s.radio = (k == KIND_BLE);
    s.kind = k;
    s.time_us = t;
    s.identity = id;
    s.identity_length = 6'(IDENTITY_BYTES_DEF);
    s.label_length = $urandom_range(0, 3) == 0 ? 8'd0 :
                     8'($urandom_range(1, LABEL_BYTES_DEF));
    s.rssi_dbm = 8'($urandom);
    s.frequency_khz = 24'($urandom);
    s.channel = 8'($urandom);
    s.facts_word = $urandom;
    return s;
  endfunction

  // Mostly well-formed sightings on a pooled identity, some corrupted.
  function automatic sighting_t random_sighting();
    sighting_t s;
    logic [1:0] k;
    int pick;
    k = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) s = good_sighting(k, 48'({$urandom, $urandom}), 48'd0);
    else s = good_sighting(k, id_pool[$urandom_range(0, 15)], 48'd0);
    pick = $urandom_range(0, 19);
    if (pick < 2) s.time_us = clock_us - 48'($urandom_range(1, 500));
    else if (pick < 3) s.time_us = clock_us;
    else begin
      clock_us = clock_us + 48'($urandom_range(0, 1000));
      s.time_us = clock_us;
    end
    case ($urandom_range(0, 11))
      0: s.kind = 2'($urandom);
      1: s.radio = ~s.radio;
      2: s.identity_length = 6'($urandom);
      3: s.label_length = 8'($urandom);
      4: s.time_us = 48'd0;
      default: ;
    endcase
    if ($urandom_range(0, 20) == 0) begin
      s.time_us = 48'({$urandom, $urandom});
      s.identity = 48'({$urandom, $urandom});
    end
    return s;
  endfunction

  initial begin
    sighting_t s;
    int gap;
    for (int i = 0; i < 16; i++) id_pool[i] = 48'({$urandom, $urandom});
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: at least one of each validity failure.
    s = good_sighting(KIND_AP, 48'hFFFF_FFFF_FFFF, 48'd5);
    s.radio = 1'b1; send_sighting(s);
    s = good_sighting(KIND_BLE, 48'd1, 48'd5);
    s.radio = 1'b0; send_sighting(s);
    s = good_sighting(KIND_AP, 48'd1, 48'd5);
    s.kind = 2'd3; send_sighting(s);
    s = good_sighting(KIND_AP, 48'd1, 48'd0); send_sighting(s);
    s = good_sighting(KIND_AP, 48'd1, 48'd5);
    s.identity_length = 6'h3F; send_sighting(s);
    s = good_sighting(KIND_AP, 48'd1, 48'd5);
    s.label_length = 8'(LABEL_BYTES_DEF + 1); send_sighting(s);
    s.label_length = 8'hFF; send_sighting(s);
    // Add, equal time with equal rssi, stronger, weaker, out of order.
    s = good_sighting(KIND_AP, 48'd0, 48'hFFFF_FFFF_FFF0);
    s.rssi_dbm = 8'sh80; s.label_length = 8'd0; send_sighting(s);
    s.label_length = 8'(LABEL_BYTES_DEF); send_sighting(s);
    s.rssi_dbm = 8'sd127; s.label_length = 8'd3; s.time_us = 48'hFFFF_FFFF_FFFF;
    send_sighting(s);
    s.rssi_dbm = 8'sd0; s.label_length = 8'd9; send_sighting(s);
    s.time_us = 48'd1; send_sighting(s);
    // Same identity under another kind is a distinct entry.
    s = good_sighting(KIND_STA, 48'd0, 48'd7); send_sighting(s);
    s = good_sighting(KIND_BLE, 48'hFFFF_FFFF_FFFF, 48'd7);
    s.frequency_khz = 24'hFF_FFFF; s.channel = 8'hFF; s.facts_word = '1;
    send_sighting(s);
    // Fill the table past capacity.
    for (int i = 0; i < CAP + 3; i++) begin
      s = good_sighting(KIND_STA, 48'h8000_0000_0000 + 48'(i), 48'd9);
      send_sighting(s);
    end
    in_valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (CAP + 10) @(posedge clk);

    // Reset is not reused, so fresh entries cannot be added; still hits on
    // pooled ids would miss. Pool ids into the range used by the fill, most of it in the table.
    for (int i = 0; i < 16; i++) begin
      id_pool[i] = 48'h8000_0000_0000 + 48'($urandom_range(0, CAP + 2));
    end
    @(negedge clk);
    for (int n = 0; n < N_RANDOM; ) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (gap > 0) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      repeat ($urandom_range(1, 10)) begin
        s = random_sighting();
        if (s.kind != KIND_STA) s.kind = KIND_STA;
        if ($urandom_range(0, 5) == 0) s.kind = 2'($urandom);
        if ($urandom_range(0, 7) == 0) s.radio = 1'($urandom);
        send_sighting(s);
        n++;
      end
    end
    in_valid <= 1'b0;

    wait (sb.pending.size() == 0);
    repeat (CAP + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
